### src/rcf_pkg.sv
// Shared types, control codes and microcode table of the RGBA colour fade block.
`timescale 1ns / 1ps
package rcf_pkg;

  typedef logic [3:0] pc_t;
  typedef logic [3:0] op_t;
  typedef logic [2:0] cond_t;

  // Commands carried in the input beat's tuser
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_SET   = 2'd3;

  // Datapath operations
  localparam op_t OP_NOP   = 4'd0;
  localparam op_t OP_LATCH = 4'd1;
  localparam op_t OP_START = 4'd2;
  localparam op_t OP_STOP  = 4'd3;
  localparam op_t OP_SET   = 4'd4;
  localparam op_t OP_TADD  = 4'd5;
  localparam op_t OP_LDEND = 4'd6;
  localparam op_t OP_MUL   = 4'd7;
  localparam op_t OP_DIV   = 4'd8;
  localparam op_t OP_ACC   = 4'd9;
  localparam op_t OP_APPLY = 4'd10;
  localparam op_t OP_OUT   = 4'd11;

  // Sequencer conditions
  localparam cond_t C_NEXT       = 3'd0;
  localparam cond_t C_JUMP       = 3'd1;
  localparam cond_t C_DISPATCH   = 3'd2;
  localparam cond_t C_NOT_FADING = 3'd3;
  localparam cond_t C_GE_LEN     = 3'd4;
  localparam cond_t C_BIT_MORE   = 3'd5;
  localparam cond_t C_CH_MORE    = 3'd6;
  localparam cond_t C_WAIT_OUT   = 3'd7;

  // Program addresses
  localparam pc_t PC_IDLE   = 4'd0;
  localparam pc_t PC_START  = 4'd1;
  localparam pc_t PC_STOP   = 4'd2;
  localparam pc_t PC_SET    = 4'd3;
  localparam pc_t PC_TICK   = 4'd4;
  localparam pc_t PC_LDEND  = 4'd5;
  localparam pc_t PC_MUL    = 4'd6;
  localparam pc_t PC_DIV    = 4'd7;
  localparam pc_t PC_ACC    = 4'd8;
  localparam pc_t PC_FINISH = 4'd9;
  localparam pc_t PC_OUT    = 4'd10;

  localparam logic [31:0] WHITE_RGBA = 32'hFFFF_FFFF;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   tgt;
  } ucode_t;

  typedef struct packed {
    op_t  op;
    logic go;
  } dp_ctrl_t;

  typedef struct packed {
    logic not_fading;
    logic ge_len;
    logic bit_more;
    logic ch_more;
    logic out_busy;
  } dp_stat_t;

  function automatic ucode_t ucode(input pc_t pc);
    ucode_t w;
    case (pc)
      PC_IDLE:   w = '{OP_LATCH, C_DISPATCH,   PC_IDLE};
      PC_START:  w = '{OP_START, C_JUMP,       PC_OUT};
      PC_STOP:   w = '{OP_STOP,  C_JUMP,       PC_OUT};
      PC_SET:    w = '{OP_SET,   C_JUMP,       PC_OUT};
      PC_TICK:   w = '{OP_TADD,  C_NOT_FADING, PC_OUT};
      PC_LDEND:  w = '{OP_LDEND, C_GE_LEN,     PC_FINISH};
      PC_MUL:    w = '{OP_MUL,   C_NEXT,       PC_IDLE};
      PC_DIV:    w = '{OP_DIV,   C_BIT_MORE,   PC_DIV};
      PC_ACC:    w = '{OP_ACC,   C_CH_MORE,    PC_MUL};
      PC_FINISH: w = '{OP_APPLY, C_NEXT,       PC_IDLE};
      PC_OUT:    w = '{OP_OUT,   C_WAIT_OUT,   PC_IDLE};
      default:   w = '{OP_NOP,   C_JUMP,       PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic pc_t dispatch(input logic [1:0] cmd);
    pc_t p;
    case (cmd)
      CMD_TICK:  p = PC_TICK;
      CMD_START: p = PC_START;
      CMD_STOP:  p = PC_STOP;
      CMD_SET:   p = PC_SET;
      default:   p = PC_IDLE;
    endcase
    return p;
  endfunction

  // Channel 0 is red, held in the top byte
  function automatic logic [7:0] get_chan(input logic [31:0] c, input logic [1:0] k);
    logic [7:0] v;
    case (k)
      2'd0:    v = c[31:24];
      2'd1:    v = c[23:16];
      2'd2:    v = c[15:8];
      default: v = c[7:0];
    endcase
    return v;
  endfunction

  function automatic logic [31:0] set_chan(input logic [31:0] c, input logic [1:0] k,
                                           input logic [7:0] v);
    logic [31:0] r;
    r = c;
    case (k)
      2'd0:    r[31:24] = v;
      2'd1:    r[23:16] = v;
      2'd2:    r[15:8]  = v;
      default: r[7:0]   = v;
    endcase
    return r;
  endfunction

endpackage

### src/rcf_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps
module rcf_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [1:0]      in_cmd,
  input  rcf_pkg::dp_stat_t stat,
  output rcf_pkg::dp_ctrl_t ctrl
);
  import rcf_pkg::*;

  pc_t    pc_r, pc_nxt;
  ucode_t uw;
  logic   go;

  assign uw        = ucode(pc_r);
  assign in_tready = (pc_r == PC_IDLE);
  assign go        = in_tvalid && in_tready;
  assign ctrl.op   = uw.op;
  assign ctrl.go   = go;

  always_comb begin
    case (uw.cond)
      C_NEXT:       pc_nxt = pc_r + 4'd1;
      C_JUMP:       pc_nxt = uw.tgt;
      C_DISPATCH:   pc_nxt = go ? dispatch(in_cmd) : pc_r;
      C_NOT_FADING: pc_nxt = stat.not_fading ? uw.tgt : pc_r + 4'd1;
      C_GE_LEN:     pc_nxt = stat.ge_len ? uw.tgt : pc_r + 4'd1;
      C_BIT_MORE:   pc_nxt = stat.bit_more ? uw.tgt : pc_r + 4'd1;
      C_CH_MORE:    pc_nxt = stat.ch_more ? uw.tgt : pc_r + 4'd1;
      C_WAIT_OUT:   pc_nxt = stat.out_busy ? pc_r : uw.tgt;
      default:      pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n) pc_r <= PC_OUT)
    else $error("step counter left the program");

  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> (pc_r == PC_START || pc_r == PC_STOP || pc_r == PC_SET || pc_r == PC_TICK))
    else $error("accepted beat did not dispatch to a command routine");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r != PC_IDLE) |=> !$past(go))
    else $error("beat accepted outside the idle step");

endmodule

### src/rcf_datapath.sv
// Fade datapath: colour state, item registers, multiplier, divide step and output register.
`timescale 1ns / 1ps
module rcf_datapath #(
  parameter int TIME_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rcf_pkg::dp_ctrl_t ctrl,
  output rcf_pkg::dp_stat_t stat,
  input  logic [63:0]       in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic [1:0]        out_tuser
);
  import rcf_pkg::*;

  localparam int CW = TIME_BITS + 8;

  logic [31:0]          tint_r, tint_nxt, start_r, start_nxt, end_r, end_nxt;
  logic [31:0]          col_r, col_nxt;
  logic [TIME_BITS-1:0] len_r, len_nxt, ms_r, ms_nxt, dur_r, dur_nxt;
  logic [CW-1:0]        total_r, total_nxt, num_r, num_nxt;
  logic [31:0]          tgt_r, tgt_nxt;
  logic                 fading_r, fading_nxt, changed_r, changed_nxt;
  logic                 neg_r, neg_nxt;
  logic [7:0]           quo_r, quo_nxt;
  logic [2:0]           bi_r, bi_nxt;
  logic [1:0]           ch_r, ch_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic [31:0]          odata_r, odata_nxt;
  logic [1:0]           ouser_r, ouser_nxt;

  logic [CW:0]   sum;
  logic [CW-1:0] lim;
  logic [7:0]    s_ch, e_ch, mag;
  logic [8:0]    q9, acc9;
  logic          out_busy;

  assign out_busy = ovalid_r && !out_tready;
  assign s_ch     = get_chan(start_r, ch_r);
  assign e_ch     = get_chan(end_r, ch_r);
  assign mag      = (e_ch < s_ch) ? (s_ch - e_ch) : (e_ch - s_ch);
  assign sum      = {1'b0, total_r} + CW'(ms_r);
  assign lim      = CW'(len_r) << bi_r;
  assign q9       = neg_r ? (9'd0 - {1'b0, quo_r}) : {1'b0, quo_r};
  assign acc9     = {1'b0, s_ch} + q9;

  assign stat.not_fading = !fading_r;
  assign stat.ge_len     = (total_r >= CW'(len_r));
  assign stat.bit_more   = (bi_r != 3'd0);
  assign stat.ch_more    = (ch_r != 2'd3);
  assign stat.out_busy   = out_busy;

  always_comb begin
    tint_nxt    = tint_r;
    start_nxt   = start_r;
    end_nxt     = end_r;
    col_nxt     = col_r;
    len_nxt     = len_r;
    ms_nxt      = ms_r;
    dur_nxt     = dur_r;
    total_nxt   = total_r;
    num_nxt     = num_r;
    tgt_nxt     = tgt_r;
    fading_nxt  = fading_r;
    changed_nxt = changed_r;
    neg_nxt     = neg_r;
    quo_nxt     = quo_r;
    bi_nxt      = bi_r;
    ch_nxt      = ch_r;
    odata_nxt   = odata_r;
    ouser_nxt   = ouser_r;
    ovalid_nxt  = out_tready ? 1'b0 : ovalid_r;
    case (ctrl.op)
      OP_LATCH: begin
        if (ctrl.go) begin
          ms_nxt      = TIME_BITS'(in_tdata[15:0]);
          tgt_nxt     = {in_tdata[23:16], in_tdata[31:24], in_tdata[39:32], in_tdata[47:40]};
          dur_nxt     = TIME_BITS'(in_tdata[63:48]);
          changed_nxt = 1'b0;
        end
      end
      OP_START: begin
        if (tgt_r != tint_r) begin
          start_nxt  = tint_r;
          end_nxt    = tgt_r;
          total_nxt  = '0;
          len_nxt    = dur_r;
          fading_nxt = 1'b1;
        end
      end
      OP_STOP: begin
        end_nxt    = tint_r;
        fading_nxt = 1'b0;
      end
      OP_SET: begin
        if (end_r != tint_r) fading_nxt = 1'b0;
        if (tgt_r != tint_r) begin
          tint_nxt    = tgt_r;
          changed_nxt = 1'b1;
        end
      end
      OP_TADD: begin
        if (fading_r) begin
          // saturate the running total
          total_nxt = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
        end
      end
      OP_LDEND: begin
        col_nxt = end_r;
        ch_nxt  = 2'd0;
      end
      OP_MUL: begin
        // total is below the length here, so its low bits hold it all
        num_nxt = CW'(mag) * CW'(total_r[TIME_BITS-1:0]);
        neg_nxt = (e_ch < s_ch);
        quo_nxt = 8'd0;
        bi_nxt  = 3'd7;
      end
      OP_DIV: begin
        if (num_r >= lim) begin
          num_nxt       = num_r - lim;
          quo_nxt[bi_r] = 1'b1;
        end
        bi_nxt = bi_r - 3'd1;
      end
      OP_ACC: begin
        col_nxt = set_chan(col_r, ch_r, acc9[7:0]);
        ch_nxt  = ch_r + 2'd1;
      end
      OP_APPLY: begin
        if (col_r != tint_r) begin
          tint_nxt    = col_r;
          changed_nxt = 1'b1;
          if (col_r == end_r) fading_nxt = 1'b0;
        end
      end
      OP_OUT: begin
        if (!out_busy) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {tint_r[7:0], tint_r[15:8], tint_r[23:16], tint_r[31:24]};
          ouser_nxt  = {fading_r, changed_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tint_r   <= WHITE_RGBA;
      start_r  <= WHITE_RGBA;
      end_r    <= WHITE_RGBA;
      len_r    <= '0;
      total_r  <= '0;
      fading_r <= 1'b0;
      ovalid_r <= 1'b0;
      bi_r     <= 3'd0;
      ch_r     <= 2'd0;
    end else begin
      tint_r   <= tint_nxt;
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      len_r    <= len_nxt;
      total_r  <= total_nxt;
      fading_r <= fading_nxt;
      ovalid_r <= ovalid_nxt;
      bi_r     <= bi_nxt;
      ch_r     <= ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r     <= col_nxt;
    ms_r      <= ms_nxt;
    dur_r     <= dur_nxt;
    num_r     <= num_nxt;
    tgt_r     <= tgt_nxt;
    changed_r <= changed_nxt;
    neg_r     <= neg_nxt;
    quo_r     <= quo_nxt;
    odata_r   <= odata_nxt;
    ouser_r   <= ouser_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  a_fade_target: assert property (@(posedge clk) disable iff (!rst_n)
    fading_r |-> (end_r != tint_r))
    else $error("fade running towards the colour already shown");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_DIV) |-> ({1'b0, num_r} < ((CW + 1)'(len_r) << ({1'b0, bi_r} + 4'd1))))
    else $error("partial remainder too large for the quotient bits left");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_OUT && !out_busy) |=> out_tvalid)
    else $error("result not presented after output step");

endmodule

### src/rgba_color_fade.sv
// RGBA colour fade: top level joining the microcode sequencer and the fade datapath.
// Every command ends in the output step, which registers the result: start, stop, set colour
// and idle ticks go there at once; a tick ending the fade first applies the end colour; an
// interpolating tick runs four channel passes of one multiply, eight divide steps and one
// accumulate. One item is in flight at a time; a held output stalls the next beat.
// Synchronous active-low reset restores opaque white, no fade, and an empty output.
`timescale 1ns / 1ps
module rgba_color_fade #(
  parameter int TIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // elapsed_ms[15:0], target_red[23:16], target_green[31:24], target_blue[39:32],
  // target_alpha[47:40], duration_ms[63:48]
  input  logic [63:0] in_tdata,
  // command[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tint_red[7:0], tint_green[15:8], tint_blue[23:16], tint_alpha[31:24]
  output logic [31:0] out_tdata,
  // tint_changed[0], fade_active[1]
  output logic [1:0]  out_tuser
);
  import rcf_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  rcf_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  rcf_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### verif/rgba_color_fade_test.sv
// Self-checking stream testbench for the RGBA colour fade block.
`timescale 1ns / 1ps
module rgba_color_fade_test;
  import rcf_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    rgba_t tint;
    logic  changed;
    logic  active;
  } tint_report_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] ms;
    rgba_t       target;
    logic [15:0] dur;
    bit          known;
    rgba_t       tint;
    bit          changed;
    bit          active;
  } plan_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = CMD_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  // Predicted state of the fade
  rgba_t       tint      = 32'hFFFF_FFFF;
  rgba_t       fade_from = 32'hFFFF_FFFF;
  rgba_t       fade_to   = 32'hFFFF_FFFF;
  logic [15:0] fade_len  = '0;
  logic [23:0] elapsed_sum = '0;
  logic        fade_on   = 1'b0;

  tint_report_t pending_tints[$];
  plan_row_t    plan[$];
  int           mismatches  = 0;
  int           live_items  = 0;
  int           quiet_cycles = 0;
  int           src_gap_pct  = 35;
  int           sink_stall_pct = 64;

  rgba_color_fade DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Per channel: from + (to - from) * elapsed / length, truncated toward zero
  function automatic rgba_t blend_channels();
    logic [31:0] from_v, to_v, mix_v;
    longint      base, span, step;
    from_v = fade_from;
    to_v   = fade_to;
    mix_v  = '0;
    for (int k = 0; k < 4; k++) begin
      base = longint'(from_v[31-8*k -: 8]);
      span = longint'(to_v[31-8*k -: 8]) - base;
      step = (span * longint'(elapsed_sum)) / longint'(fade_len);
      mix_v[31-8*k -: 8] = 8'(base + step);
    end
    return rgba_t'(mix_v);
  endfunction

  task automatic advance_fade(input logic [1:0] cmd, input logic [15:0] ms,
                              input rgba_t target, input logic [15:0] dur,
                              output tint_report_t rep);
    rgba_t       next_tint;
    logic [24:0] sum;
    rep.changed = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (fade_on) begin
          sum = {1'b0, elapsed_sum} + 25'(ms);
          elapsed_sum = sum[24] ? '1 : sum[23:0];
          next_tint = (elapsed_sum >= {8'd0, fade_len}) ? fade_to : blend_channels();
          if (next_tint != tint) begin
            tint = next_tint;
            rep.changed = 1'b1;
            if (next_tint == fade_to) fade_on = 1'b0;
          end
        end
      end
      CMD_START: begin
        if (target != tint) begin
          fade_from   = tint;
          fade_to     = target;
          elapsed_sum = '0;
          fade_len    = dur;
          fade_on     = 1'b1;
        end
      end
      CMD_STOP: begin
        fade_to = tint;
        fade_on = 1'b0;
      end
      CMD_SET: begin
        if (fade_to != tint) fade_on = 1'b0;
        if (target != tint) begin
          tint = target;
          rep.changed = 1'b1;
        end
      end
    endcase
    rep.tint   = tint;
    rep.active = fade_on;
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [15:0] ms, input rgba_t target,
                           input logic [15:0] dur, input bit known, input tint_report_t typed);
    tint_report_t rep;
    while ($urandom_range(99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {dur, target.alpha, target.blue, target.green, target.red, ms};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    live_items++;
    advance_fade(cmd, ms, target, dur, rep);
    pending_tints.push_back(known ? typed : rep);
  endtask

  function automatic logic [15:0] pick_duration();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'($urandom);
    return 16'($urandom_range(400, 1));
  endfunction

  // Mostly start-then-tick runs with random colours; the rest is raw noise
  task automatic random_fade_runs(input int goal);
    tint_report_t none;
    logic [15:0]  dur;
    rgba_t        target;
    int           r, n;
    none = '0;
    while (live_items < goal) begin
      if ($urandom_range(99) < 75) begin
        dur = pick_duration();
        target = ($urandom_range(19) == 0) ? tint : rgba_t'($urandom);
        send_item(CMD_START, 16'($urandom), target, dur, 1'b0, none);
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(99);
          if (r < 5)
            send_item(CMD_STOP, 16'($urandom), rgba_t'($urandom), 16'($urandom), 1'b0, none);
          else if (r < 10)
            send_item(CMD_SET, 16'($urandom), rgba_t'($urandom), 16'($urandom), 1'b0, none);
          else if (r < 14)
            send_item(CMD_START, 16'($urandom), rgba_t'($urandom), pick_duration(), 1'b0, none);
          else if (r < 24)
            send_item(CMD_TICK, 16'($urandom), rgba_t'($urandom), 16'($urandom), 1'b0, none);
          else
            send_item(CMD_TICK, 16'($urandom_range(32'(dur) / 4 + 1, 0)), rgba_t'($urandom),
                      16'($urandom), 1'b0, none);
        end
      end else begin
        send_item(2'($urandom), 16'($urandom), rgba_t'($urandom), 16'($urandom), 1'b0, none);
      end
    end
  endtask

  always @(posedge clk) begin : result_sink
    tint_report_t want, got;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got.tint    = {out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tdata[31:24]};
        got.changed = out_tuser[0];
        got.active  = out_tuser[1];
        if (pending_tints.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected beat: tint %h changed %b active %b",
                     got.tint, got.changed, got.active);
        end else begin
          want = pending_tints.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: tint %h/%h changed %b/%b active %b/%b (expected/actual)",
                       want.tint, got.tint, want.changed, got.changed,
                       want.active, got.active);
          end
        end
      end
    end
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    tint_report_t typed;
    // Directed rows: cmd, ms, target, dur, known, tint, changed, active
    plan.push_back('{CMD_TICK,  16'hFFFF, 32'h0000_0000, 16'h0000, 1, 32'hFFFF_FFFF, 0, 0});
    plan.push_back('{CMD_START, 16'h0000, 32'hFFFF_FFFF, 16'd100,  1, 32'hFFFF_FFFF, 0, 0});
    plan.push_back('{CMD_SET,   16'h0000, 32'h0000_0000, 16'hFFFF, 1, 32'h0000_0000, 1, 0});
    plan.push_back('{CMD_SET,   16'hFFFF, 32'h0000_0000, 16'h0000, 1, 32'h0000_0000, 0, 0});
    plan.push_back('{CMD_START, 16'h0000, 32'hFFFF_FFFF, 16'h0000, 1, 32'h0000_0000, 0, 1});
    plan.push_back('{CMD_TICK,  16'h0000, 32'h0000_0000, 16'h0000, 1, 32'hFFFF_FFFF, 1, 0});
    plan.push_back('{CMD_START, 16'h0000, 32'h00FF_8040, 16'hFFFF, 1, 32'hFFFF_FFFF, 0, 1});
    plan.push_back('{CMD_TICK,  16'h0000, 32'h0000_0000, 16'h0000, 1, 32'hFFFF_FFFF, 0, 1});
    plan.push_back('{CMD_TICK,  16'd1000, 32'h0000_0000, 16'h0000, 0, 32'h0, 0, 0});
    plan.push_back('{CMD_TICK,  16'h7FFF, 32'h0000_0000, 16'h0000, 0, 32'h0, 0, 0});
    plan.push_back('{CMD_START, 16'h0000, 32'h1234_5678, 16'd10,   0, 32'h0, 0, 0});
    plan.push_back('{CMD_TICK,  16'd3,    32'h0000_0000, 16'h0000, 0, 32'h0, 0, 0});
    plan.push_back('{CMD_STOP,  16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, 32'h0, 0, 0});
    plan.push_back('{CMD_TICK,  16'd5,    32'h0000_0000, 16'h0000, 0, 32'h0, 0, 0});
    plan.push_back('{CMD_START, 16'h0000, 32'h0000_0000, 16'd1,    0, 32'h0, 0, 0});
    plan.push_back('{CMD_SET,   16'h0000, 32'hAA55_AA55, 16'h0000, 1, 32'hAA55_AA55, 1, 0});
    plan.push_back('{CMD_START, 16'h0000, 32'h0000_0000, 16'd2,    1, 32'hAA55_AA55, 0, 1});
    plan.push_back('{CMD_TICK,  16'd1,    32'h0000_0000, 16'h0000, 0, 32'h0, 0, 0});
    plan.push_back('{CMD_TICK,  16'hFFFF, 32'h0000_0000, 16'h0000, 1, 32'h0000_0000, 1, 0});
    plan.push_back('{CMD_START, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 1, 32'h0000_0000, 0, 1});
    plan.push_back('{CMD_TICK,  16'h7FFF, 32'h0000_0000, 16'h0000, 0, 32'h0, 0, 0});
    plan.push_back('{CMD_TICK,  16'hFFFF, 32'h0000_0000, 16'h0000, 1, 32'hFFFF_FFFF, 1, 0});
    plan.push_back('{CMD_SET,   16'h0000, 32'hFFFF_FFFF, 16'h0000, 1, 32'hFFFF_FFFF, 0, 0});
    plan.push_back('{CMD_START, 16'h0000, 32'h0000_0000, 16'd3,    1, 32'hFFFF_FFFF, 0, 1});
    // Set to the current tint mid-fade: the fade drops, the tint holds
    plan.push_back('{CMD_SET,   16'h0000, 32'hFFFF_FFFF, 16'h0000, 1, 32'hFFFF_FFFF, 0, 0});
    plan.push_back('{CMD_STOP,  16'h0000, 32'h0000_0000, 16'h0000, 1, 32'hFFFF_FFFF, 0, 0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_gap_pct    = 35;
    sink_stall_pct = 64;
    foreach (plan[i]) begin
      typed.tint    = plan[i].tint;
      typed.changed = plan[i].changed;
      typed.active  = plan[i].active;
      send_item(plan[i].cmd, plan[i].ms, plan[i].target, plan[i].dur, plan[i].known, typed);
    end
    random_fade_runs(300);
    src_gap_pct    = 64;
    sink_stall_pct = 35;
    random_fade_runs(600);
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    random_fade_runs(900);
    in_tvalid <= 1'b0;

    // Drain, then give any stray beat time to show up
    while (pending_tints.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_tints.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
